>>> sv/tcc_pkg.sv
// Shared widths and register codes for the tiled cell to coordinates block.
package tcc_pkg;

	localparam int CELL_W  = 40;
	localparam int COL_W   = 24;
	localparam int ROW_W   = 16;
	localparam int TCOL_W  = 25;
	localparam int TROW_W  = 17;
	localparam int TILE_W  = 17;
	localparam int CFG_W   = 25;
	localparam int CIDX_W  = 2;
	localparam int SPAN_W  = TCOL_W + TILE_W;
	localparam int AREA_W  = TCOL_W + TROW_W;
	localparam int PTILE_W = TILE_W + TILE_W;

	typedef enum logic [CIDX_W-1:0] {
		CFG_TOTAL_COLUMNS    = 2'd0,
		CFG_TOTAL_ROWS       = 2'd1,
		CFG_COLUMNS_PER_TILE = 2'd2,
		CFG_ROWS_PER_TILE    = 2'd3
	} cfg_idx_t;

endpackage

>>> sv/tcc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with side payload.
module tcc_div #(
	parameter int DVD_W  = 40,
	parameter int DSR_W  = 42,
	parameter int QUO_W  = 17,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [DVD_W-1:0]  dvd,
	input  logic [DSR_W-1:0]  dsr,
	input  logic [SIDE_W-1:0] side_in,
	output logic              out_vld,
	output logic [QUO_W-1:0]  quo,
	output logic [DVD_W-1:0]  rem,
	output logic [SIDE_W-1:0] side_out
);

	localparam int CW = (DVD_W > DSR_W) ? DVD_W : DSR_W;

	logic              vld_s  [QUO_W];
	logic [DVD_W-1:0]  rem_s  [QUO_W];
	logic [DSR_W-1:0]  dsr_s  [QUO_W];
	logic [QUO_W-1:0]  quo_s  [QUO_W];
	logic [SIDE_W-1:0] side_s [QUO_W];

	genvar i;
	for (i = 0; i < QUO_W; i++) begin : g_stage
		localparam int SH = QUO_W - 1 - i;
		logic              pv;
		logic [DVD_W-1:0]  prem;
		logic [DSR_W-1:0]  pdsr;
		logic [QUO_W-1:0]  pquo;
		logic [SIDE_W-1:0] pside;
		logic              fit;
		logic [DVD_W-1:0]  nrem;

		if (i == 0) begin : g_first
			assign pv    = in_vld;
			assign prem  = dvd;
			assign pdsr  = dsr;
			assign pquo  = '0;
			assign pside = side_in;
		end else begin : g_next
			assign pv    = vld_s[i-1];
			assign prem  = rem_s[i-1];
			assign pdsr  = dsr_s[i-1];
			assign pquo  = quo_s[i-1];
			assign pside = side_s[i-1];
		end

		always_comb begin
			fit  = (CW'(prem) >> SH) >= CW'(pdsr);
			nrem = fit ? DVD_W'(CW'(prem) - (CW'(pdsr) << SH)) : prem;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= nrem;
				dsr_s[i]  <= pdsr;
				quo_s[i]  <= pquo | (QUO_W'(fit) << SH);
				side_s[i] <= pside;
			end
		end
	end

	assign out_vld  = vld_s[QUO_W-1];
	assign quo      = quo_s[QUO_W-1];
	assign rem      = rem_s[QUO_W-1];
	assign side_out = side_s[QUO_W-1];

endmodule

>>> sv/tiled_cell_to_coordinates.sv
// Top level: linear cell index in tiled storage order to global column and row.
//
// Use: write the four size registers through cfg_we/cfg_index/cfg_data while
// the block is idle; writes act through derived size registers. Requests
// arrive on cell_valid/cell_stall with cell_index; each request gives one
// result on coord_valid/coord_stall with column_index, row_index and
// out_of_range. An index at or past columns times rows returns out_of_range
// with zero indices.
// Three divider chains of 17, 25 and 17 one-bit stages set the depth,
// plus nine stages for range check, tile size products and the final adds.
// Throughput is one request per cycle while no stall freezes the pipeline.
// Reset clears all valid bits and sets every size register to 1.
// A stall on coord_stall while a result is shown freezes the whole pipeline
// and raises cell_stall in the same cycle; nothing is lost or repeated.
module tiled_cell_to_coordinates #(
	parameter longint unsigned MAX_COLUMNS = 64'd16777216,
	parameter longint unsigned MAX_ROWS    = 64'd65536
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tcc_pkg::CIDX_W-1:0]        cfg_index,
	input  logic [tcc_pkg::CFG_W-1:0]         cfg_data,
	input  logic                              cell_valid,
	output logic                              cell_stall,
	input  logic [tcc_pkg::CELL_W-1:0]        cell_index,
	output logic                              coord_valid,
	input  logic                              coord_stall,
	output logic [tcc_pkg::COL_W-1:0]         column_index,
	output logic [tcc_pkg::ROW_W-1:0]         row_index,
	output logic                              out_of_range
);

	localparam int CELL_W  = tcc_pkg::CELL_W;
	localparam int TCOL_W  = tcc_pkg::TCOL_W;
	localparam int TROW_W  = tcc_pkg::TROW_W;
	localparam int TILE_W  = tcc_pkg::TILE_W;
	localparam int SPAN_W  = tcc_pkg::SPAN_W;
	localparam int AREA_W  = tcc_pkg::AREA_W;
	localparam int PTILE_W = tcc_pkg::PTILE_W;
	localparam int COL_W   = tcc_pkg::COL_W;
	localparam int ROW_W   = tcc_pkg::ROW_W;
	localparam int TRTH_W  = TROW_W + TILE_W;
	localparam int TCTW_W  = TCOL_W + TILE_W;

	// configuration
	logic [TCOL_W-1:0] tot_cols_q;
	logic [TROW_W-1:0] tot_rows_q;
	logic [TILE_W-1:0] col_tile_q;
	logic [TILE_W-1:0] row_tile_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_cols_q <= TCOL_W'(1);
			tot_rows_q <= TROW_W'(1);
			col_tile_q <= TILE_W'(1);
			row_tile_q <= TILE_W'(1);
		end else if (cfg_we) begin
			unique case (tcc_pkg::cfg_idx_t'(cfg_index))
				tcc_pkg::CFG_TOTAL_COLUMNS:    tot_cols_q <= cfg_data;
				tcc_pkg::CFG_TOTAL_ROWS:       tot_rows_q <= TROW_W'(cfg_data);
				tcc_pkg::CFG_COLUMNS_PER_TILE: col_tile_q <= TILE_W'(cfg_data);
				tcc_pkg::CFG_ROWS_PER_TILE:    row_tile_q <= TILE_W'(cfg_data);
				default: ;
			endcase
		end
	end

	// derived sizes
	logic [TCOL_W-1:0] cols_q;
	logic [TROW_W-1:0] rows_q;
	logic [TILE_W-1:0] tw_q;
	logic [TILE_W-1:0] th_q;
	logic [SPAN_W-1:0] span_q;
	logic [AREA_W-1:0] area_q;

	always_ff @(posedge clk) begin
		cols_q <= (64'(tot_cols_q) > MAX_COLUMNS) ? TCOL_W'(MAX_COLUMNS) : tot_cols_q;
		rows_q <= (64'(tot_rows_q) > MAX_ROWS) ? TROW_W'(MAX_ROWS) : tot_rows_q;
		tw_q   <= (col_tile_q == '0) ? TILE_W'(1) : col_tile_q;
		th_q   <= (row_tile_q == '0) ? TILE_W'(1) : row_tile_q;
		span_q <= SPAN_W'(cols_q) * SPAN_W'(th_q);
		area_q <= AREA_W'(cols_q) * AREA_W'(rows_q);
	end

	logic en;
	assign en         = !(coord_valid && coord_stall);
	assign cell_stall = !en;

	// s1..s3: capture, align with derived sizes, range check
	logic              vld_s1, vld_s2, vld_s3;
	logic [CELL_W-1:0] idx_s1, idx_s2, idx_s3;
	logic              oor_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= cell_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= cell_index;
			idx_s2 <= idx_s1;
			idx_s3 <= idx_s2;
			oor_s3 <= AREA_W'(idx_s2) >= area_q;
		end
	end

	// tile row
	logic              d1_vld;
	logic [TROW_W-1:0] d1_quo;
	logic [CELL_W-1:0] d1_rem;
	logic              d1_oor;

	tcc_div #(
		.DVD_W (CELL_W),
		.DSR_W (SPAN_W),
		.QUO_W (TROW_W),
		.SIDE_W(1)
	) u_div_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s3),
		.dvd     (idx_s3),
		.dsr     (span_q),
		.side_in (oor_s3),
		.out_vld (d1_vld),
		.quo     (d1_quo),
		.rem     (d1_rem),
		.side_out(d1_oor)
	);

	// s4..s6: rows in this tile row, tile area
	logic               vld_s4, vld_s5, vld_s6;
	logic [TRTH_W-1:0]  trth_s4;
	logic [ROW_W-1:0]   trth_s5, trth_s6;
	logic [CELL_W-1:0]  rem_s4, rem_s5, rem_s6;
	logic               oor_s4, oor_s5, oor_s6;
	logic [TILE_W-1:0]  rh_s5;
	logic [PTILE_W-1:0] ptile_s6;
	logic [TRTH_W-1:0]  rows_left;

	assign rows_left = TRTH_W'(rows_q) - trth_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s4 <= d1_vld;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			trth_s4  <= TRTH_W'(d1_quo) * TRTH_W'(th_q);
			rem_s4   <= d1_rem;
			oor_s4   <= d1_oor;
			rh_s5    <= (TRTH_W'(th_q) <= rows_left) ? th_q : TILE_W'(rows_left);
			trth_s5  <= ROW_W'(trth_s4);
			rem_s5   <= rem_s4;
			oor_s5   <= oor_s4;
			ptile_s6 <= PTILE_W'(tw_q) * PTILE_W'(rh_s5);
			trth_s6  <= trth_s5;
			rem_s6   <= rem_s5;
			oor_s6   <= oor_s5;
		end
	end

	// tile column
	localparam int SIDE2_W = 1 + ROW_W;

	logic               d2_vld;
	logic [TCOL_W-1:0]  d2_quo;
	logic [CELL_W-1:0]  d2_rem;
	logic [SIDE2_W-1:0] d2_side;

	tcc_div #(
		.DVD_W (CELL_W),
		.DSR_W (PTILE_W),
		.QUO_W (TCOL_W),
		.SIDE_W(SIDE2_W)
	) u_div_col (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.dvd     (rem_s6),
		.dsr     (ptile_s6),
		.side_in ({oor_s6, trth_s6}),
		.out_vld (d2_vld),
		.quo     (d2_quo),
		.rem     (d2_rem),
		.side_out(d2_side)
	);

	// s7..s8: columns in this tile
	logic               vld_s7, vld_s8;
	logic [TCTW_W-1:0]  tctw_s7;
	logic [COL_W-1:0]   tctw_s8;
	logic [PTILE_W-1:0] rem_s7, rem_s8;
	logic [SIDE2_W-1:0] side_s7, side_s8;
	logic [TILE_W-1:0]  ch_s8;
	logic [TCTW_W-1:0]  cols_left;

	assign cols_left = TCTW_W'(cols_q) - tctw_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s7 <= d2_vld;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tctw_s7 <= TCTW_W'(d2_quo) * TCTW_W'(tw_q);
			rem_s7  <= PTILE_W'(d2_rem);
			side_s7 <= d2_side;
			ch_s8   <= (TCTW_W'(tw_q) <= cols_left) ? tw_q : TILE_W'(cols_left);
			tctw_s8 <= COL_W'(tctw_s7);
			rem_s8  <= rem_s7;
			side_s8 <= side_s7;
		end
	end

	// row and column inside the tile
	localparam int SIDE3_W = SIDE2_W + COL_W;

	logic               d3_vld;
	logic [TILE_W-1:0]  d3_quo;
	logic [PTILE_W-1:0] d3_rem;
	logic [SIDE3_W-1:0] d3_side;

	tcc_div #(
		.DVD_W (PTILE_W),
		.DSR_W (TILE_W),
		.QUO_W (TILE_W),
		.SIDE_W(SIDE3_W)
	) u_div_cell (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s8),
		.dvd     (rem_s8),
		.dsr     (ch_s8),
		.side_in ({side_s8, tctw_s8}),
		.out_vld (d3_vld),
		.quo     (d3_quo),
		.rem     (d3_rem),
		.side_out(d3_side)
	);

	// s9: result register
	logic             oor_d3;
	logic [ROW_W-1:0] trth_d3;
	logic [COL_W-1:0] tctw_d3;

	assign oor_d3  = d3_side[SIDE3_W-1];
	assign trth_d3 = d3_side[SIDE3_W-2:COL_W];
	assign tctw_d3 = d3_side[COL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_valid <= 1'b0;
		end else if (en) begin
			coord_valid <= d3_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_of_range <= oor_d3;
			column_index <= oor_d3 ? '0 : COL_W'(tctw_d3 + COL_W'(d3_rem));
			row_index    <= oor_d3 ? '0 : ROW_W'(trth_d3 + ROW_W'(d3_quo));
		end
	end

endmodule
